// File: design/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int EQ_SCALE = 1000;
    localparam int WIDE_W = 66;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
        ACT_EQ = 4'd4, ACT_NE = 4'd5, ACT_LT = 4'd6, ACT_LE = 4'd7,
        ACT_GT = 4'd8, ACT_GE = 4'd9, ACT_INC = 4'd10, ACT_DEC = 4'd11,
        ACT_RED = 4'd12
    } action_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // divider request/response between sequencer and divider
    typedef struct packed {
        logic               start;
        logic [WIDE_W-1:0]  dividend;
        logic [WIDE_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [WIDE_W-1:0]  quot;
        logic [WIDE_W-1:0]  rem;
    } div_rsp_t;
endpackage

// File: design/rau_div.sv
// shared restoring divider, one quotient bit per cycle on unsigned magnitudes
`timescale 1ns / 1ps
module rau_div
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CW = $clog2(WIDE_W + 1);

    logic [WIDE_W-1:0] q_reg, q_next;
    logic [WIDE_W-1:0] r_reg, r_next;
    logic [WIDE_W-1:0] d_reg, d_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WIDE_W:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[WIDE_W-1]} - {1'b0, d_reg};
        if (req.start)
        begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            cnt_next = CW'(WIDE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDE_W])
            begin
                r_next = trial[WIDE_W-1:0];
                q_next = {q_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[WIDE_W-2:0], q_reg[WIDE_W-1]};
                q_next = {q_reg[WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem = r_reg;
endmodule

// File: design/rational_arithmetic_unit.sv
// rational arithmetic unit: sequencer around one shared multiplier and divider
// undefined actions and zero denominators or divisors go from idle straight to the result state
// a gcd takes one divide per euclid step
// one beat at a time; in_stall is high from acceptance until the result is taken
// reset: asynchronous active-low rst_n returns the sequencer to idle, no result held
`timescale 1ns / 1ps
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [3:0]                    action,
    input  logic signed [VALUE_WIDTH-1:0] num_a,
    input  logic signed [VALUE_WIDTH-1:0] den_a,
    input  logic signed [VALUE_WIDTH-1:0] num_b,
    input  logic signed [VALUE_WIDTH-1:0] den_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] num_out,
    output logic [VALUE_WIDTH-2:0]        den_out,
    output logic                          truth,
    output logic [1:0]                    status
);
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [VALUE_WIDTH_DEF:0] mop_t;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_NSEL  = 12'b000000000010,
        S_GCD   = 12'b000000000100,
        S_GWAIT = 12'b000000001000,
        S_QN    = 12'b000000010000,
        S_QNW   = 12'b000000100000,
        S_QD    = 12'b000001000000,
        S_QDW   = 12'b000010000000,
        S_FIX   = 12'b000100000000,
        S_MUL   = 12'b001000000000,
        S_FLW   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    // normalize targets: 0 operand a, 1 operand b, 2 result
    state_t st_reg, st_next;
    logic [1:0] tgt_reg, tgt_next;
    logic [2:0] step_reg, step_next;
    logic [3:0] act_reg, act_next;
    wide_t na_reg, na_next, da_reg, da_next, nb_reg, nb_next, db_reg, db_next;
    wide_t rn_reg, rn_next, rd_reg, rd_next;
    wide_t gx_reg, gx_next, gy_reg, gy_next;
    wide_t fa_reg, fa_next;
    logic fneg_reg, fneg_next;
    logic signed [VALUE_WIDTH-1:0] on_reg, on_next;
    logic [VALUE_WIDTH-2:0] od_reg, od_next;
    logic tr_reg, tr_next;
    logic [1:0] stt_reg, stt_next;

    div_req_t dreq;
    div_rsp_t drsp;

    rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    mop_t mul_a, mul_b;
    wide_t mul_p;
    wide_t cur_n, cur_d;
    wide_t res_n, res_d;
    logic [WIDE_W-1:0] qmag;
    logic uses_b;
    wide_t lim_hi, lim_lo;

    assign lim_hi = (wide_t'(1) <<< (VALUE_WIDTH - 1)) - wide_t'(1);
    assign lim_lo = -lim_hi - wide_t'(1);
    assign uses_b = act_reg <= ACT_GE;

    function automatic logic [WIDE_W-1:0] mag_f(input wide_t v);
        mag_f = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    function automatic logic inr(input wide_t v, input wide_t lo, input wide_t hi);
        inr = (v >= lo) && (v <= hi);
    endfunction

    // shared multiplier, operands chosen by sequencer step
    assign mul_p = wide_t'(mul_a) * wide_t'(mul_b);

    always_comb
    begin
        cur_n = na_reg;
        cur_d = da_reg;
        case (tgt_reg)
            2'd1:
            begin
                cur_n = nb_reg;
                cur_d = db_reg;
            end
            2'd2:
            begin
                cur_n = rn_reg;
                cur_d = rd_reg;
            end
            default:
            begin
                cur_n = na_reg;
                cur_d = da_reg;
            end
        endcase
    end

    assign qmag = fneg_reg ? WIDE_W'(-drsp.quot) : drsp.quot;

    always_comb
    begin
        st_next = st_reg;
        tgt_next = tgt_reg;
        step_next = step_reg;
        act_next = act_reg;
        na_next = na_reg; da_next = da_reg; nb_next = nb_reg; db_next = db_reg;
        rn_next = rn_reg; rd_next = rd_reg;
        gx_next = gx_reg; gy_next = gy_reg;
        fa_next = fa_reg; fneg_next = fneg_reg;
        on_next = on_reg; od_next = od_reg; tr_next = tr_reg; stt_next = stt_reg;
        dreq = '0;
        mul_a = '0;
        mul_b = '0;
        res_n = '0;
        res_d = '0;
        case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = action;
                    na_next = wide_t'(num_a); da_next = wide_t'(den_a);
                    nb_next = wide_t'(num_b); db_next = wide_t'(den_b);
                    on_next = '0; od_next = '0; tr_next = 1'b0; stt_next = ST_OK;
                    tgt_next = 2'd0;
                    if (action > ACT_RED)
                        st_next = S_OUT;
                    else if (den_a == '0 || (action <= ACT_GE && den_b == '0)
                             || (action == ACT_DIV && num_b == '0))
                    begin
                        stt_next = ST_ZERO;
                        st_next = S_OUT;
                    end
                    else
                        st_next = S_NSEL;
                end
            end
            S_NSEL:
            begin
                gx_next = wide_t'(mag_f(cur_n));
                gy_next = wide_t'(mag_f(cur_d));
                st_next = S_GCD;
            end
            S_GCD:
            begin
                if (gx_reg == '0)
                begin
                    fneg_next = cur_n[WIDE_W-1];
                    dreq.start = 1'b1;
                    dreq.dividend = mag_f(cur_n);
                    dreq.divisor = gy_reg;
                    st_next = S_QNW;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = gy_reg;
                    dreq.divisor = gx_reg;
                    st_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (drsp.done)
                begin
                    gy_next = gx_reg;
                    gx_next = wide_t'(drsp.rem);
                    st_next = S_GCD;
                end
            end
            S_QNW:
            begin
                if (drsp.done)
                begin
                    fa_next = wide_t'(qmag);
                    fneg_next = cur_d[WIDE_W-1];
                    dreq.start = 1'b1;
                    dreq.dividend = mag_f(cur_d);
                    dreq.divisor = gy_reg;
                    st_next = S_QDW;
                end
            end
            S_QDW:
            begin
                if (drsp.done)
                begin
                    if (fneg_reg)
                    begin
                        res_n = -fa_reg;
                        res_d = wide_t'(drsp.quot);
                    end
                    else
                    begin
                        res_n = fa_reg;
                        res_d = wide_t'(drsp.quot);
                    end
                    st_next = S_FIX;
                    case (tgt_reg)
                        2'd0:
                        begin
                            na_next = res_n; da_next = res_d;
                            if (uses_b)
                            begin
                                tgt_next = 2'd1;
                                st_next = S_NSEL;
                            end
                            else
                            begin
                                step_next = 3'd0;
                                st_next = S_MUL;
                            end
                        end
                        2'd1:
                        begin
                            nb_next = res_n; db_next = res_d;
                            step_next = 3'd0;
                            st_next = S_MUL;
                        end
                        default:
                        begin
                            rn_next = res_n; rd_next = res_d;
                            st_next = S_FIX;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // one product per cycle into registers
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = mop_t'(na_reg); mul_b = mop_t'(db_reg);
                        gx_next = mul_p;
                    end
                    3'd1:
                    begin
                        mul_a = (act_reg == ACT_MUL) ? mop_t'(na_reg) : mop_t'(nb_reg);
                        mul_b = (act_reg == ACT_MUL) ? mop_t'(nb_reg) : mop_t'(da_reg);
                        gy_next = mul_p;
                    end
                    3'd2:
                    begin
                        mul_a = mop_t'(da_reg); mul_b = mop_t'(db_reg);
                        fa_next = mul_p;
                    end
                    default:
                    begin
                        st_next = S_OUT;
                        case (act_reg)
                            ACT_ADD:
                            begin
                                rn_next = gx_reg + gy_reg; rd_next = fa_reg;
                            end
                            ACT_SUB:
                            begin
                                rn_next = gx_reg - gy_reg; rd_next = fa_reg;
                            end
                            ACT_MUL:
                            begin
                                rn_next = gy_reg; rd_next = fa_reg;
                            end
                            ACT_DIV:
                            begin
                                rn_next = gx_reg; rd_next = gy_reg;
                            end
                            ACT_INC:
                            begin
                                rn_next = na_reg + da_reg; rd_next = da_reg;
                            end
                            ACT_DEC:
                            begin
                                rn_next = na_reg - da_reg; rd_next = da_reg;
                            end
                            default:
                            begin
                                rn_next = na_reg; rd_next = da_reg;
                            end
                        endcase
                        if (act_reg >= ACT_EQ && act_reg <= ACT_GE)
                        begin
                            if (act_reg == ACT_EQ || act_reg == ACT_NE)
                            begin
                                step_next = 3'd4;
                                st_next = S_FLW;
                            end
                            else
                            begin
                                case (act_reg)
                                    ACT_LT: tr_next = gx_reg < gy_reg;
                                    ACT_LE: tr_next = gx_reg <= gy_reg;
                                    ACT_GT: tr_next = gx_reg > gy_reg;
                                    default: tr_next = gx_reg >= gy_reg;
                                endcase
                            end
                        end
                        else if (act_reg <= ACT_DIV)
                            st_next = S_FIX;
                        else
                            st_next = S_FIX;
                    end
                endcase
            end
            S_FLW:
            begin
                // floor(1000*n/d) for a then b, one divide each
                case (step_reg)
                    3'd4:
                    begin
                        mul_a = mop_t'(na_reg); mul_b = mop_t'(EQ_SCALE);
                        fneg_next = mul_p[WIDE_W-1];
                        dreq.start = 1'b1;
                        dreq.dividend = mag_f(mul_p);
                        dreq.divisor = da_reg;
                        step_next = 3'd5;
                    end
                    3'd5:
                    begin
                        if (drsp.done)
                        begin
                            fa_next = fneg_reg ?
                                (-wide_t'(drsp.quot) - ((drsp.rem != '0) ? wide_t'(1) : '0))
                                : wide_t'(drsp.quot);
                            step_next = 3'd6;
                        end
                    end
                    3'd6:
                    begin
                        mul_a = mop_t'(nb_reg); mul_b = mop_t'(EQ_SCALE);
                        fneg_next = mul_p[WIDE_W-1];
                        dreq.start = 1'b1;
                        dreq.dividend = mag_f(mul_p);
                        dreq.divisor = db_reg;
                        step_next = 3'd7;
                    end
                    default:
                    begin
                        if (drsp.done)
                        begin
                            res_n = fneg_reg ?
                                (-wide_t'(drsp.quot) - ((drsp.rem != '0) ? wide_t'(1) : '0))
                                : wide_t'(drsp.quot);
                            tr_next = (res_n == fa_reg) ^ (act_reg == ACT_NE);
                            st_next = S_OUT;
                        end
                    end
                endcase
            end
            S_FIX:
            begin
                if (tgt_reg != 2'd2 && act_reg <= ACT_DIV)
                begin
                    if (!inr(rn_reg, lim_lo, lim_hi) || !inr(rd_reg, lim_lo, lim_hi))
                    begin
                        stt_next = ST_OVF;
                        st_next = S_OUT;
                    end
                    else
                    begin
                        tgt_next = 2'd2;
                        st_next = S_NSEL;
                    end
                end
                else
                begin
                    st_next = S_OUT;
                    if (!inr(rn_reg, lim_lo, lim_hi) || !inr(rd_reg, lim_lo, lim_hi))
                        stt_next = ST_OVF;
                    else
                    begin
                        on_next = rn_reg[VALUE_WIDTH-1:0];
                        od_next = rd_reg[VALUE_WIDTH-2:0];
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            tgt_reg <= 2'd0;
            step_reg <= 3'd0;
        end
        else
        begin
            st_reg <= st_next;
            tgt_reg <= tgt_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        na_reg <= na_next; da_reg <= da_next; nb_reg <= nb_next; db_reg <= db_next;
        rn_reg <= rn_next; rd_reg <= rd_next;
        gx_reg <= gx_next; gy_reg <= gy_next;
        fa_reg <= fa_next; fneg_reg <= fneg_next;
        on_reg <= on_next; od_reg <= od_next; tr_reg <= tr_next; stt_reg <= stt_next;
    end

    assign in_stall = (st_reg != S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign num_out = (stt_reg == ST_OK) ? on_reg : '0;
    assign den_out = (stt_reg == ST_OK) ? od_reg : '0;
    assign truth = (stt_reg == ST_OK) ? tr_reg : 1'b0;
    assign status = stt_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall)) else $error("result shown while idle");
    a_ret_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !in_stall) else $error("no return to idle");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3)) else $error("bad status");
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truth |-> num_out == '0 && den_out == '0)
        else $error("comparison with fraction");
endmodule

// File: tb/tb_rational_arithmetic_unit.sv
// testbench for the rational arithmetic unit: directed and random beats, checked by table or predictor
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               truth;
        logic [1:0]         status;
    } fraction_result_t;

    typedef struct {
        logic [3:0]         act;
        logic signed [31:0] na;
        logic signed [31:0] da;
        logic signed [31:0] nb;
        logic signed [31:0] db;
        bit                 typed;
        fraction_result_t   res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] action = '0;
    logic signed [31:0] num_a = '0;
    logic signed [31:0] den_a = '0;
    logic signed [31:0] num_b = '0;
    logic signed [31:0] den_b = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [31:0] num_out;
    logic [30:0] den_out;
    logic truth;
    logic [1:0] status;

    fraction_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int max_in_gap = 11;
    int max_out_gap = 11;
    int per_action[16];

    always #5 clk = ~clk;

    rational_arithmetic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .num_out   (num_out),
        .den_out   (den_out),
        .truth     (truth),
        .status    (status)
    );

    function automatic bit fits_value(logic signed [65:0] v);
        return v >= VAL_MIN && v <= VAL_MAX;
    endfunction

    function automatic void lowest_terms(inout longint n, inout longint d);
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        x = n < 0 ? -n : n;
        y = d < 0 ? -d : d;
        while (x != 0)
        begin
            t = y % x;
            y = x;
            x = t;
        end
        n = n / longint'(y);
        d = d / longint'(y);
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
    endfunction

    function automatic longint floor_milli(longint n, longint d);
        longint t;
        longint q;
        t = n * EQ_SCALE;
        q = t / d;
        if (t % d != 0 && t < 0)
            q--;
        return q;
    endfunction

    function automatic fraction_result_t rational_result(logic [3:0] act, longint na,
                                                         longint da, longint nb, longint db);
        fraction_result_t r;
        logic signed [65:0] wn;
        logic signed [65:0] wd;
        longint rn;
        longint rd;
        longint lhs;
        longint rhs;
        bit uses_b;
        bit t;
        r = '{num: '0, den: '0, truth: 1'b0, status: ST_OK};
        uses_b = act <= ACT_GE;
        if (act > ACT_RED)
            return r;
        if (da == 0 || (uses_b && db == 0) || (act == ACT_DIV && nb == 0))
        begin
            r.status = ST_ZERO;
            return r;
        end
        lowest_terms(na, da);
        if (uses_b)
            lowest_terms(nb, db);
        if (act >= ACT_EQ && act <= ACT_GE)
        begin
            lhs = na * db;
            rhs = nb * da;
            case (act)
                ACT_EQ: t = floor_milli(na, da) == floor_milli(nb, db);
                ACT_NE: t = floor_milli(na, da) != floor_milli(nb, db);
                ACT_LT: t = lhs < rhs;
                ACT_LE: t = lhs <= rhs;
                ACT_GT: t = lhs > rhs;
                default: t = lhs >= rhs;
            endcase
            r.truth = t;
            return r;
        end
        case (act)
            ACT_ADD: begin wn = 66'(na * db) + 66'(nb * da); wd = 66'(da * db); end
            ACT_SUB: begin wn = 66'(na * db) - 66'(nb * da); wd = 66'(da * db); end
            ACT_MUL: begin wn = 66'(na * nb); wd = 66'(da * db); end
            ACT_DIV: begin wn = 66'(na * db); wd = 66'(nb * da); end
            ACT_INC: begin wn = 66'(na + da); wd = 66'(da); end
            ACT_DEC: begin wn = 66'(na - da); wd = 66'(da); end
            default: begin wn = 66'(na); wd = 66'(da); end
        endcase
        if (!fits_value(wn) || !fits_value(wd))
        begin
            r.status = ST_OVF;
            return r;
        end
        rn = longint'(wn);
        rd = longint'(wd);
        if (act <= ACT_DIV)
            lowest_terms(rn, rd);
        if (rn < VAL_MIN || rn > VAL_MAX || rd < VAL_MIN || rd > VAL_MAX)
        begin
            r.status = ST_OVF;
            return r;
        end
        r.num = rn[31:0];
        r.den = rd[30:0];
        return r;
    endfunction

    task automatic send_beat(stim_row_t row);
        int gap;
        gap = $urandom_range(0, max_in_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= row.act;
        num_a <= row.na;
        den_a <= row.da;
        num_b <= row.nb;
        den_b <= row.db;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (row.typed)
            pending_results.push_back(row.res);
        else
            pending_results.push_back(rational_result(row.act, row.na, row.da, row.nb, row.db));
        beats_sent++;
        per_action[row.act]++;
    endtask

    function automatic logic signed [31:0] rand_operand(bit wide);
        case ($urandom_range(0, 9))
            0: return wide ? $urandom : -32'sd2147483648;
            1: return 32'sd2147483647;
            2: return 0;
            3, 4: return $signed($urandom_range(0, 2000)) - 1000;
            5, 6: return $signed($urandom_range(0, 40)) - 20;
            default: return wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    task automatic random_beat();
        stim_row_t row;
        bit wide;
        wide = $urandom_range(0, 3) == 0;
        row.act = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) != 0)
            row.act = 4'($urandom_range(ACT_ADD, ACT_RED));
        row.na = rand_operand(wide);
        row.da = rand_operand(wide);
        row.nb = rand_operand(wide);
        row.db = rand_operand(wide);
        if (row.da == 0 && $urandom_range(0, 3) != 0)
            row.da = 1;
        if (row.db == 0 && $urandom_range(0, 3) != 0)
            row.db = -7;
        row.typed = 1'b0;
        send_beat(row);
    endtask

    // result side: random stall, then take and check one beat
    initial
    begin
        fraction_result_t want;
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, max_out_gap);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (num_out !== want.num)
                begin
                    $error("num_out expected %0d actual %0d", want.num, num_out);
                    errors++;
                end
                if (den_out !== want.den)
                begin
                    $error("den_out expected %0d actual %0d", want.den, den_out);
                    errors++;
                end
                if (truth !== want.truth)
                begin
                    $error("truth expected %0d actual %0d", want.truth, truth);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    errors++;
                end
            end
            beats_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        int waited;
        rows = '{
            '{ACT_RED, 4, 8, 0, 0, 1, '{1, 2, 0, ST_OK}},
            '{ACT_RED, -6, -9, 0, 0, 1, '{2, 3, 0, ST_OK}},
            '{ACT_RED, -32'sd2147483648, -1, 0, 0, 1, '{0, 0, 0, ST_OVF}},
            '{ACT_ADD, 1, 0, 1, 2, 1, '{0, 0, 0, ST_ZERO}},
            '{ACT_SUB, 1, 2, 1, 0, 1, '{0, 0, 0, ST_ZERO}},
            '{ACT_DIV, 1, 2, 0, 5, 1, '{0, 0, 0, ST_ZERO}},
            '{ACT_LT, 1, 2, 3, 0, 1, '{0, 0, 0, ST_ZERO}},
            '{ACT_INC, 1, 2, 0, 0, 1, '{3, 2, 0, ST_OK}},
            '{ACT_DEC, 1, 2, 0, 0, 1, '{-1, 2, 0, ST_OK}},
            '{ACT_INC, 32'sd2147483647, 1, 0, 0, 1, '{0, 0, 0, ST_OVF}},
            '{ACT_DEC, -32'sd2147483648, 1, 0, 0, 1, '{0, 0, 0, ST_OVF}},
            '{ACT_MUL, 32'sd2147483647, 1, 2, 1, 1, '{0, 0, 0, ST_OVF}},
            '{ACT_EQ, 1, 3, 333, 1000, 1, '{0, 0, 1, ST_OK}},
            '{ACT_NE, 1, 3, 333, 1000, 1, '{0, 0, 0, ST_OK}},
            '{4'd13, 1, 2, 3, 4, 1, '{0, 0, 0, ST_OK}},
            '{4'd15, 0, 0, 0, 0, 1, '{0, 0, 0, ST_OK}},
            '{ACT_ADD, 1, 2, 1, 3, 0, '{0, 0, 0, ST_OK}},
            '{ACT_SUB, -5, 7, 3, -14, 0, '{0, 0, 0, ST_OK}},
            '{ACT_MUL, -32'sd2147483648, 3, 3, -32'sd2147483648, 0, '{0, 0, 0, ST_OK}},
            '{ACT_DIV, 32'sd2147483647, 2, -32'sd2147483648, 32'sd2147483647, 0,
              '{0, 0, 0, ST_OK}},
            '{ACT_LE, -1, 3, 2, -6, 0, '{0, 0, 0, ST_OK}},
            '{ACT_GT, 32'sd2147483647, 1, -32'sd2147483648, 1, 0, '{0, 0, 0, ST_OK}},
            '{ACT_GE, -2, 4, -1, 2, 0, '{0, 0, 0, ST_OK}},
            '{ACT_ADD, -32'sd2147483648, 1, -32'sd2147483648, 1, 0, '{0, 0, 0, ST_OK}},
            '{ACT_EQ, -1, 3, -334, 1000, 0, '{0, 0, 0, ST_OK}}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_beat(rows[i]);
        for (int n = 0; n < 430; n++)
        begin
            if (n % 100 == 0)
            begin
                max_in_gap = (n == 200) ? 0 : 11;
                max_out_gap = (n == 200) ? 0 : 11;
            end
            if (n == 150)
            begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            random_beat();
        end
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("sent %0d beats, checked %0d results", beats_sent, beats_checked);
        $display("add %0d sub %0d mul %0d div %0d cmp %0d inc/dec %0d reduce %0d other %0d",
                 per_action[0], per_action[1], per_action[2], per_action[3],
                 per_action[4] + per_action[5] + per_action[6] + per_action[7]
                 + per_action[8] + per_action[9], per_action[10] + per_action[11],
                 per_action[12], per_action[13] + per_action[14] + per_action[15]);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: files.f
design/rau_pkg.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
tb/tb_rational_arithmetic_unit.sv
